// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on i_clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (cons)) else $error(msg);

`endif

// ----- rtl/pdts_pkg.sv -----
// ----------------------------------------------------------------------------
// pdts_pkg
// Types and codes for the bus function table: entry layout, stream payloads,
// operation and status codes.
// ----------------------------------------------------------------------------
package pdts_pkg;

    // Operation selector carried on the input tuser
    localparam logic [1:0] MODE_INSERT  = 2'd0;
    localparam logic [1:0] MODE_FIND_ID = 2'd1;
    localparam logic [1:0] MODE_FIND_CL = 2'd2;
    localparam logic [1:0] MODE_GET     = 2'd3;

    // Result status carried on the output tuser
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_ABSENT    = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic [15:0] VENDOR_ABSENT = 16'hFFFF;
    localparam logic [7:0]  SUB_WILDCARD  = 8'hFF;

    // Stored entry, bus in the top byte
    typedef struct packed {
        logic [7:0]  bus;
        logic [4:0]  slot;
        logic [2:0]  func;
        logic [15:0] vendor;
        logic [15:0] product;
        logic [7:0]  cls;
        logic [7:0]  sub;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Input tdata, last listed field in the lowest bits
    typedef struct packed {
        logic [7:0]  entry_number;
        logic [7:0]  subclass_value;
        logic [7:0]  class_value;
        logic [15:0] product_code;
        logic [15:0] vendor_code;
        logic [2:0]  function_number;
        logic [4:0]  slot_number;
        logic [7:0]  bus_number;
    } t_in_data;

    // Output tdata, last listed field in the lowest bits
    typedef struct packed {
        logic [2:0]  pad;
        logic [6:0]  entry_total;
        logic [7:0]  hit_subclass;
        logic [7:0]  hit_class;
        logic [15:0] hit_product;
        logic [15:0] hit_vendor;
        logic [2:0]  hit_function;
        logic [4:0]  hit_slot;
        logic [7:0]  hit_bus;
        logic [5:0]  hit_index;
    } t_out_data;

endpackage

// ----- rtl/pci_device_table_search.sv -----
// ----------------------------------------------------------------------------
// pci_device_table_search
// Table of discovered bus functions: insert, find by vendor and device ID,
// find by class and subclass, read by index.
// Input stream: tuser selects the operation, tdata holds the function record,
// search keys and index. Output stream: tuser holds the status, tdata the
// entry found or written, its index and the entry count after the operation.
// One transaction is worked on at a time; the result sits in an output
// register, so the next transaction is taken while an earlier result waits.
// An insert goes straight to the result; a read by index reads the entry at
// that index (an index that is not held goes straight to the result); a search
// scans from index 0 and stops at the first match or after the last entry.
// The scan reads the entry memory once a cycle through its single read port
// and compares the data of the previous read. Reset clears the entry count
// and empties the output; entry contents are not cleared. While the receiver
// stalls, the result holds and a finished following result waits internally
// until the output register frees up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pci_device_table_search
    import pdts_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // bus[7:0] slot[12:8] function[15:13] vendor[31:16] product[47:32]
    // class[55:48] subclass[63:56] entry_number[71:64]
    input  logic [71:0] i_s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // hit_index[5:0] bus[13:6] slot[18:14] function[21:19] vendor[37:22]
    // product[53:38] class[61:54] subclass[69:62] entry_total[76:70] zero[79:77]
    output logic [79:0] o_m_axis_tdata,
    // status[1:0]
    output logic [1:0]  o_m_axis_tuser
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [ENTRY_W-1:0] mem [MAX_ENTRIES];

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_addr, n_addr;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_idx;
    t_entry        r_rd_data;
    t_in_data      r_req, n_req;
    logic [1:0]    r_mode, n_mode;
    logic [1:0]    r_pend_status, n_pend_status;
    logic [5:0]    r_pend_idx, n_pend_idx;
    t_entry        r_pend_entry, n_pend_entry;
    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_out_status, n_out_status;
    t_out_data     r_out_data, n_out_data;

    t_in_data      w_in;
    t_entry        w_new_entry;
    logic          w_accept;
    logic          w_rd_en;
    logic          w_we;
    logic          w_match;
    logic          w_out_free;
    logic [8:0]    w_count9;
    logic [8:0]    w_rd_idx9;

    assign w_in      = t_in_data'(i_s_axis_tdata);
    assign w_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_count9  = 9'(r_count);
    assign w_rd_idx9 = 9'(r_rd_idx);
    assign w_rd_en   = (r_state == S_SCAN) && (r_addr < r_count);
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    assign w_new_entry.bus     = w_in.bus_number;
    assign w_new_entry.slot    = w_in.slot_number;
    assign w_new_entry.func    = w_in.function_number;
    assign w_new_entry.vendor  = w_in.vendor_code;
    assign w_new_entry.product = w_in.product_code;
    assign w_new_entry.cls     = w_in.class_value;
    assign w_new_entry.sub     = w_in.subclass_value;

    always_comb begin
        case (r_mode)
            MODE_FIND_ID: w_match = (r_rd_data.vendor == r_req.vendor_code) &&
                                    (r_rd_data.product == r_req.product_code);
            MODE_FIND_CL: w_match = (r_rd_data.cls == r_req.class_value) &&
                                    ((r_req.subclass_value == SUB_WILDCARD) ||
                                     (r_rd_data.sub == r_req.subclass_value));
            MODE_GET:     w_match = 1'b1;
            default:      w_match = 1'b0;
        endcase
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_addr        = r_addr;
        n_req         = r_req;
        n_mode        = r_mode;
        n_pend_status = r_pend_status;
        n_pend_idx    = r_pend_idx;
        n_pend_entry  = r_pend_entry;
        n_out_valid   = r_out_valid;
        n_out_status  = r_out_status;
        n_out_data    = r_out_data;
        w_we          = 1'b0;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_req         = w_in;
                    n_mode        = i_s_axis_tuser;
                    n_pend_status = ST_NOT_FOUND;
                    n_pend_idx    = '0;
                    n_pend_entry  = '0;
                    n_addr        = '0;
                    case (i_s_axis_tuser)
                        MODE_INSERT: begin
                            n_state = S_EMIT;
                            if (r_count >= CW'(MAX_ENTRIES)) begin
                                n_pend_status = ST_FULL;
                            end else if (w_in.vendor_code == VENDOR_ABSENT) begin
                                n_pend_status = ST_ABSENT;
                            end else begin
                                w_we          = 1'b1;
                                n_pend_status = ST_OK;
                                n_pend_idx    = w_count9[5:0];
                                n_pend_entry  = w_new_entry;
                                n_count       = r_count + 1'b1;
                            end
                        end
                        MODE_GET: begin
                            if ({1'b0, w_in.entry_number} < w_count9) begin
                                n_addr  = CW'(w_in.entry_number);
                                n_state = S_SCAN;
                            end else begin
                                n_state = S_EMIT;
                            end
                        end
                        default: begin
                            n_state = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_rd_vld && w_match) begin
                    n_pend_status = ST_OK;
                    n_pend_idx    = w_rd_idx9[5:0];
                    n_pend_entry  = r_rd_data;
                    n_state       = S_EMIT;
                end else if (r_addr >= r_count) begin
                    n_pend_status = ST_NOT_FOUND;
                    n_pend_idx    = '0;
                    n_pend_entry  = '0;
                    n_state       = S_EMIT;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_EMIT: begin
                // hold the result until the output register frees up
                if (w_out_free) begin
                    n_out_valid             = 1'b1;
                    n_out_status            = r_pend_status;
                    n_out_data.pad          = '0;
                    n_out_data.entry_total  = w_count9[6:0];
                    n_out_data.hit_subclass = r_pend_entry.sub;
                    n_out_data.hit_class    = r_pend_entry.cls;
                    n_out_data.hit_product  = r_pend_entry.product;
                    n_out_data.hit_vendor   = r_pend_entry.vendor;
                    n_out_data.hit_function = r_pend_entry.func;
                    n_out_data.hit_slot     = r_pend_entry.slot;
                    n_out_data.hit_bus      = r_pend_entry.bus;
                    n_out_data.hit_index    = r_pend_idx;
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Entry memory: write on insert in idle, read during the scan only
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_count[AW-1:0]] <= w_new_entry;
        end
        if (w_rd_en) begin
            r_rd_data <= t_entry'(mem[r_addr[AW-1:0]]);
            r_rd_idx  <= r_addr[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_vld    <= w_rd_en;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr        <= n_addr;
        r_req         <= n_req;
        r_mode        <= n_mode;
        r_pend_status <= n_pend_status;
        r_pend_idx    <= n_pend_idx;
        r_pend_entry  <= n_pend_entry;
        r_out_status  <= n_out_status;
        r_out_data    <= n_out_data;
    end

    // take nothing while reset is held
    assign o_s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_status;

    `ASSERT_ALWAYS(a_count_bound, r_count <= CW'(MAX_ENTRIES),
        "entry count beyond table depth")
    `ASSERT_ALWAYS(a_scan_in_range, !(r_rd_vld && (r_state == S_SCAN)) ||
        (AW'(r_rd_idx) < r_count) || (r_count == CW'(MAX_ENTRIES)),
        "scan read outside the held entries")
    `ASSERT_NEXT(a_insert_counts, w_accept && (i_s_axis_tuser == MODE_INSERT) &&
        (r_count < CW'(MAX_ENTRIES)) && (w_in.vendor_code != VENDOR_ABSENT),
        r_count == $past(r_count) + 1'b1, "accepted insert did not add an entry")
    `ASSERT_NEXT(a_emit_waits, (r_state == S_EMIT) && r_out_valid && !i_m_axis_tready,
        (r_state == S_EMIT), "pending result dropped while output stalled")

endmodule

// ----- tb/pci_device_table_search_tb.sv -----
// ----------------------------------------------------------------------------
// pci_device_table_search_tb
// Self-checking bench for the bus function table. Drives insert, find-by-ID,
// find-by-class and read-by-index transactions on the input stream, keeps a
// shadow copy of the table and compares each output transaction, field by
// field, against the result predicted for the oldest outstanding operation.
// Sender gaps and receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------
module pci_device_table_search_tb;
    import pdts_pkg::*;

    localparam int TABLE_DEPTH    = 64;
    localparam int RANDOM_OPS     = 1080;
    localparam int PHASE_OPS      = 135;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 100;

    typedef struct packed {
        logic [1:0] status;
        t_out_data  data;
    } t_lookup_result;

    class lookup_scoreboard;
        t_entry         entries [TABLE_DEPTH];
        int unsigned    held;
        t_lookup_result awaited [$];
        int unsigned    fails;

        function new();
            held  = 0;
            fails = 0;
        endfunction

        // Work out the result of one accepted operation and queue it
        function void note_request(logic [1:0] mode, t_in_data req);
            t_lookup_result r;
            int             hit;
            logic           match;
            hit      = -1;
            r.status = ST_NOT_FOUND;
            r.data   = '0;
            case (mode)
                MODE_INSERT: begin
                    if (held >= TABLE_DEPTH) begin
                        r.status = ST_FULL;
                    end else if (req.vendor_code == VENDOR_ABSENT) begin
                        r.status = ST_ABSENT;
                    end else begin
                        entries[held] = {req.bus_number, req.slot_number,
                                         req.function_number, req.vendor_code,
                                         req.product_code, req.class_value,
                                         req.subclass_value};
                        hit  = int'(held);
                        held = held + 1;
                    end
                end
                MODE_GET: begin
                    if (req.entry_number < held)
                        hit = int'(req.entry_number);
                end
                default: begin
                    // scan from index 0, first match wins
                    for (int i = 0; i < int'(held) && hit < 0; i++) begin
                        if (mode == MODE_FIND_ID)
                            match = entries[i].vendor == req.vendor_code &&
                                    entries[i].product == req.product_code;
                        else
                            match = entries[i].cls == req.class_value &&
                                    (req.subclass_value == SUB_WILDCARD ||
                                     entries[i].sub == req.subclass_value);
                        if (match)
                            hit = i;
                    end
                end
            endcase
            if (hit >= 0) begin
                r.status            = ST_OK;
                r.data.hit_index    = hit[5:0];
                r.data.hit_bus      = entries[hit].bus;
                r.data.hit_slot     = entries[hit].slot;
                r.data.hit_function = entries[hit].func;
                r.data.hit_vendor   = entries[hit].vendor;
                r.data.hit_product  = entries[hit].product;
                r.data.hit_class    = entries[hit].cls;
                r.data.hit_subclass = entries[hit].sub;
            end
            r.data.entry_total = held[6:0];
            awaited.push_back(r);
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0h got %0h", $time, field, want, got);
                fails++;
            end
        endfunction

        function void check_result(logic [1:0] status, t_out_data got);
            t_lookup_result want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result, status %0d data %h",
                         $time, status, got);
                fails++;
                return;
            end
            want = awaited.pop_front();
            compare("status", want.status, status);
            compare("hit_index", want.data.hit_index, got.hit_index);
            compare("hit_bus", want.data.hit_bus, got.hit_bus);
            compare("hit_slot", want.data.hit_slot, got.hit_slot);
            compare("hit_function", want.data.hit_function, got.hit_function);
            compare("hit_vendor", want.data.hit_vendor, got.hit_vendor);
            compare("hit_product", want.data.hit_product, got.hit_product);
            compare("hit_class", want.data.hit_class, got.hit_class);
            compare("hit_subclass", want.data.hit_subclass, got.hit_subclass);
            compare("entry_total", want.data.entry_total, got.entry_total);
            compare("pad", want.data.pad, got.pad);
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [71:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;

    int          send_gap_pct   = 0;
    int          recv_stall_pct = 0;
    int          idle_cycles    = 0;
    lookup_scoreboard sb;

    pci_device_table_search #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Check results, stall the receiver and count quiet cycles
    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, t_out_data'(m_tdata));
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_op(input logic [1:0] mode, input t_in_data req);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= req;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_request(mode, req);
    endtask

    task automatic send_fields(input logic [1:0] mode, input logic [7:0] bus,
                               input logic [4:0] slot, input logic [2:0] func,
                               input logic [15:0] vendor, input logic [15:0] product,
                               input logic [7:0] cls, input logic [7:0] sub,
                               input logic [7:0] index);
        t_in_data req;
        req.bus_number      = bus;
        req.slot_number     = slot;
        req.function_number = func;
        req.vendor_code     = vendor;
        req.product_code    = product;
        req.class_value     = cls;
        req.subclass_value  = sub;
        req.entry_number    = index;
        send_op(mode, req);
    endtask

    // Keys are mostly taken from held entries so that searches hit
    task automatic send_random_op();
        t_in_data    req;
        logic [95:0] noise;
        logic [1:0]  mode;
        int          roll;
        int          pick;
        noise = {$urandom(), $urandom(), $urandom()};
        req   = noise[71:0];
        roll  = $urandom_range(0, 99);
        pick  = (sb.held > 0) ? $urandom_range(0, sb.held - 1) : 0;
        if (roll < 14) begin
            mode = MODE_INSERT;
            case ($urandom_range(0, 7))
                0: req.vendor_code = VENDOR_ABSENT;
                1, 2: begin
                    if (sb.held > 0) begin
                        req.vendor_code  = sb.entries[pick].vendor;
                        req.product_code = sb.entries[pick].product;
                        req.class_value  = sb.entries[pick].cls;
                    end
                end
                3, 4: req.class_value = 8'($urandom_range(0, 3));
                default: ;
            endcase
        end else if (roll < 42) begin
            mode = MODE_FIND_ID;
            if (sb.held > 0 && $urandom_range(0, 9) < 7) begin
                req.vendor_code  = sb.entries[pick].vendor;
                req.product_code = sb.entries[pick].product;
            end
        end else if (roll < 70) begin
            mode = MODE_FIND_CL;
            if (sb.held > 0 && $urandom_range(0, 9) < 7)
                req.class_value = sb.entries[pick].cls;
            case ($urandom_range(0, 9))
                0, 1, 2: req.subclass_value = SUB_WILDCARD;
                3, 4, 5, 6: begin
                    if (sb.held > 0)
                        req.subclass_value = sb.entries[pick].sub;
                end
                default: ;
            endcase
        end else begin
            mode = MODE_GET;
            if (sb.held > 0 && $urandom_range(0, 9) < 7)
                req.entry_number = 8'(pick);
        end
        send_op(mode, req);
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, absent function, field extremes, duplicate keys
        send_fields(MODE_GET, 8'h00, 5'h00, 3'h0, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'd0);
        send_fields(MODE_FIND_ID, 8'h00, 5'h00, 3'h0, 16'h0000, 16'h0000, 8'h00, 8'h00,
                    8'd0);
        send_fields(MODE_FIND_CL, 8'h00, 5'h00, 3'h0, 16'h0000, 16'h0000, 8'hFF,
                    SUB_WILDCARD, 8'd0);
        send_fields(MODE_INSERT, 8'h12, 5'h03, 3'h1, VENDOR_ABSENT, 16'h1111, 8'h01,
                    8'h02, 8'd0);
        send_fields(MODE_INSERT, 8'h00, 5'h00, 3'h0, 16'h0000, 16'h0000, 8'h00, 8'h00,
                    8'd0);
        send_fields(MODE_INSERT, 8'hFF, 5'h1F, 3'h7, 16'hFFFE, 16'hFFFF, 8'hFF, 8'hFF,
                    8'hFF);
        send_fields(MODE_INSERT, 8'h01, 5'h02, 3'h0, 16'h8086, 16'h1234, 8'h02, 8'h00,
                    8'd0);
        send_fields(MODE_INSERT, 8'h02, 5'h05, 3'h3, 16'h8086, 16'h1234, 8'h02, 8'h80,
                    8'd0);
        send_fields(MODE_FIND_ID, 8'h00, 5'h00, 3'h0, 16'h8086, 16'h1234, 8'h00, 8'h00,
                    8'd0);
        send_fields(MODE_FIND_ID, 8'h00, 5'h00, 3'h0, 16'hFFFE, 16'hFFFF, 8'h00, 8'h00,
                    8'd0);
        send_fields(MODE_FIND_ID, 8'h00, 5'h00, 3'h0, 16'h0000, 16'h0001, 8'h00, 8'h00,
                    8'd0);
        send_fields(MODE_FIND_ID, 8'h00, 5'h00, 3'h0, VENDOR_ABSENT, 16'hFFFF, 8'h00,
                    8'h00, 8'd0);
        send_fields(MODE_FIND_CL, 8'h00, 5'h00, 3'h0, 16'h0000, 16'h0000, 8'h02,
                    SUB_WILDCARD, 8'd0);
        send_fields(MODE_FIND_CL, 8'h00, 5'h00, 3'h0, 16'h0000, 16'h0000, 8'h02, 8'h80,
                    8'd0);
        send_fields(MODE_FIND_CL, 8'h00, 5'h00, 3'h0, 16'h0000, 16'h0000, 8'hFF,
                    SUB_WILDCARD, 8'd0);
        send_fields(MODE_FIND_CL, 8'h00, 5'h00, 3'h0, 16'h0000, 16'h0000, 8'h05, 8'h00,
                    8'd0);
        send_fields(MODE_GET, 8'h00, 5'h00, 3'h0, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'd0);
        send_fields(MODE_GET, 8'h00, 5'h00, 3'h0, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'd3);
        send_fields(MODE_GET, 8'h00, 5'h00, 3'h0, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'd4);
        send_fields(MODE_GET, 8'hFF, 5'h1F, 3'h7, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
                    8'd255);

        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % PHASE_OPS == 0) begin
                // hold off until the block has delivered everything
                s_tvalid <= 1'b0;
                while (sb.awaited.size() != 0) @(posedge clk);
                case ((n / PHASE_OPS) % 4)
                    0: begin
                        send_gap_pct   = 0;
                        recv_stall_pct = 0;
                    end
                    1: begin
                        send_gap_pct   = 63;
                        recv_stall_pct = 0;
                    end
                    2: begin
                        send_gap_pct   = 0;
                        recv_stall_pct = 63;
                    end
                    default: begin
                        send_gap_pct   = 6;
                        recv_stall_pct = 6;
                    end
                endcase
            end
            send_random_op();
        end

        s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.fails == 0 && sb.awaited.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
